// File: rtl/rbq_pkg.sv
// ----------------------------------------------------------------------------
// rbq_pkg
// Shared types and constants of the retry/backoff drop-oldest send queue.
// ----------------------------------------------------------------------------
`default_nettype none

package rbq_pkg;

    // default geometry
    localparam int DEPTH_DEF      = 128;
    localparam int DATA_WIDTH_DEF = 32;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // field widths
    localparam int QLIM_W  = 8;
    localparam int RLIM_W  = 11;
    localparam int DELAY_W = 16;
    localparam int RETRY_W = 10;
    localparam int OCC_W   = 8;

    // register reset values
    localparam logic [QLIM_W-1:0] QUEUE_LIMIT_RST = 8'd100;
    localparam logic [RLIM_W-1:0] RETRY_LIMIT_RST = 11'sd5;

    // retry counter ceiling under unlimited retries
    localparam logic [RETRY_W-1:0] RETRY_SAT = '1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUEUE_LIMIT  = 3'd0,
        CFG_RETRY_LIMIT  = 3'd1,
        CFG_BACKOFF_BASE = 3'd2,
        CFG_BACKOFF_STEP = 3'd3,
        CFG_BACKOFF_MAX  = 3'd4
    } t_cfg_idx;

    // item kinds
    typedef enum logic {
        ACT_PUSH    = 1'b0,
        ACT_OUTCOME = 1'b1
    } t_action;

    // attempt outcomes
    typedef enum logic [1:0] {
        OUT_SUCCESS = 2'd0,
        OUT_RETRY   = 2'd1,
        OUT_FAULT   = 2'd2,
        OUT_SPARE   = 2'd3
    } t_outcome;

    // result status handed from the update logic to the top level
    typedef struct packed {
        logic               head_valid;
        logic [OCC_W-1:0]   occupancy;
        logic [DELAY_W-1:0] next_delay;
        logic [RETRY_W-1:0] retries_done;
        logic               overflow_drop;
        logic               retry_drop;
        logic               head_retired;
        logic               outcome_ignored;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/rbq_ram.sv
// ----------------------------------------------------------------------------
// rbq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/rbq_ctrl.sv
// ----------------------------------------------------------------------------
// rbq_ctrl
// Queue pointers, fill count, backoff delay and retry count; configuration
// registers; drives the payload RAM and registers the result status.
// ----------------------------------------------------------------------------
`default_nettype none

module rbq_ctrl
    import rbq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_accept,
    input  wire logic                     i_action,
    input  wire logic [DATA_WIDTH-1:0]    i_payload,
    input  wire logic [1:0]               i_outcome,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]    i_cfg_data,
    output logic                          o_ram_we,
    output logic [$clog2(DEPTH)-1:0]      o_ram_waddr,
    output logic [DATA_WIDTH-1:0]         o_ram_wdata,
    output logic [$clog2(DEPTH)-1:0]      o_ram_raddr,
    output logic                          o_strobe,
    output t_status                       o_status,
    output logic                          o_fwd,
    output logic [DATA_WIDTH-1:0]         o_fwd_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > QLIM_W) ? CW : QLIM_W;

    // configuration registers
    logic [QLIM_W-1:0]  r_queue_limit;
    logic [RLIM_W-1:0]  r_retry_limit;
    logic [DELAY_W-1:0] r_backoff_base;
    logic [DELAY_W-1:0] r_backoff_step;
    logic [DELAY_W-1:0] r_backoff_max;

    // queue state
    logic [PW-1:0]      r_rp,    n_rp;
    logic [PW-1:0]      r_wp,    n_wp;
    logic [CW-1:0]      r_cnt,   n_cnt;
    logic [DELAY_W-1:0] r_delay, n_delay;
    logic [RETRY_W-1:0] r_rc,    n_rc;
    logic               r_evict, n_evict;

    // result registers
    logic               r_strobe;
    t_status            r_status, n_status;
    logic               r_fwd;
    logic [DATA_WIDTH-1:0] r_fwd_data;

    // per-item helpers
    logic               push;
    logic               overflow, rdrop, retired, ignored, remove;
    logic [LW-1:0]      qlim_ext;
    logic [CW-1:0]      lim;
    logic [CW-1:0]      drop_n;
    logic [CW:0]        rp_sum;
    logic [PW-1:0]      rp_inc, wp_inc;
    logic [DELAY_W-1:0] ceil_val, grown_delay;
    logic [DELAY_W:0]   delay_sum;
    logic [31:0]        cnt_ext;

    // effective queue limit: zero acts as one, clipped to the depth
    always_comb begin
        qlim_ext = LW'(r_queue_limit);
        if (qlim_ext == '0) begin
            qlim_ext = LW'(1);
        end else if (qlim_ext > LW'(DEPTH)) begin
            qlim_ext = LW'(DEPTH);
        end
        lim = qlim_ext[CW-1:0];
    end

    // wrapping pointer increments
    assign rp_inc = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
    assign wp_inc = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);

    // drop count and read pointer advance on an overflowing push
    always_comb begin
        drop_n = r_cnt - lim + CW'(1);
        rp_sum = (CW + 1)'(r_rp) + (CW + 1)'(drop_n);
        if (rp_sum >= (CW + 1)'(DEPTH)) begin
            rp_sum = rp_sum - (CW + 1)'(DEPTH);
        end
    end

    // linear backoff growth with ceiling
    always_comb begin
        ceil_val  = (r_backoff_max < r_backoff_base) ? r_backoff_base : r_backoff_max;
        delay_sum = {1'b0, r_delay} + {1'b0, r_backoff_step};
        if (r_delay == '0) begin
            grown_delay = r_backoff_base;
        end else if (r_delay < ceil_val) begin
            grown_delay = (delay_sum > {1'b0, ceil_val}) ? ceil_val : delay_sum[DELAY_W-1:0];
        end else begin
            grown_delay = r_delay;
        end
    end

    // next queue state for the accepted item
    always_comb begin
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_cnt    = r_cnt;
        n_delay  = r_delay;
        n_rc     = r_rc;
        n_evict  = r_evict;
        push     = 1'b0;
        overflow = 1'b0;
        rdrop    = 1'b0;
        retired  = 1'b0;
        ignored  = 1'b0;
        remove   = 1'b0;
        if (i_accept) begin
            if (i_action == ACT_PUSH) begin
                push = 1'b1;
                n_wp = wp_inc;
                if (r_cnt >= lim) begin
                    n_rp     = rp_sum[PW-1:0];
                    n_cnt    = lim;
                    overflow = 1'b1;
                    n_evict  = 1'b1;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end else if (r_cnt == '0) begin
                ignored = 1'b1;
            end else begin
                if (i_outcome == OUT_RETRY) begin
                    n_delay = grown_delay;
                    if (r_retry_limit[RLIM_W-1]) begin
                        if (r_rc != RETRY_SAT) begin
                            n_rc = r_rc + RETRY_W'(1);
                        end
                    end else if (r_rc < r_retry_limit[RETRY_W-1:0]) begin
                        n_rc = r_rc + RETRY_W'(1);
                    end else begin
                        n_rc   = '0;
                        rdrop  = 1'b1;
                        remove = 1'b1;
                    end
                end else begin
                    n_delay = '0;
                    n_rc    = '0;
                    remove  = 1'b1;
                end
                if (remove && !r_evict) begin
                    n_rp    = rp_inc;
                    n_cnt   = r_cnt - CW'(1);
                    retired = 1'b1;
                end
                n_evict = 1'b0;
            end
        end
    end

    // result status after the item
    always_comb begin
        cnt_ext                  = 32'(n_cnt);
        n_status.head_valid      = (n_cnt != '0);
        n_status.occupancy       = cnt_ext[OCC_W-1:0];
        n_status.next_delay      = n_delay;
        n_status.retries_done    = n_rc;
        n_status.overflow_drop   = overflow;
        n_status.retry_drop      = rdrop;
        n_status.head_retired    = retired;
        n_status.outcome_ignored = ignored;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_limit  <= QUEUE_LIMIT_RST;
            r_retry_limit  <= RETRY_LIMIT_RST;
            r_backoff_base <= '0;
            r_backoff_step <= '0;
            r_backoff_max  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_QUEUE_LIMIT:  r_queue_limit  <= i_cfg_data[QLIM_W-1:0];
                CFG_RETRY_LIMIT:  r_retry_limit  <= i_cfg_data[RLIM_W-1:0];
                CFG_BACKOFF_BASE: r_backoff_base <= i_cfg_data[DELAY_W-1:0];
                CFG_BACKOFF_STEP: r_backoff_step <= i_cfg_data[DELAY_W-1:0];
                CFG_BACKOFF_MAX:  r_backoff_max  <= i_cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // queue state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp     <= '0;
            r_wp     <= '0;
            r_cnt    <= '0;
            r_delay  <= '0;
            r_rc     <= '0;
            r_evict  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_rp     <= n_rp;
            r_wp     <= n_wp;
            r_cnt    <= n_cnt;
            r_delay  <= n_delay;
            r_rc     <= n_rc;
            r_evict  <= n_evict;
            r_strobe <= i_accept;
        end
    end

    // result payload, plus bypass when the new head is the word written now
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_status   <= n_status;
            r_fwd      <= push && (n_rp == r_wp);
            r_fwd_data <= i_payload;
        end
    end

    assign o_ram_we    = push;
    assign o_ram_waddr = r_wp;
    assign o_ram_wdata = i_payload;
    assign o_ram_raddr = n_rp;
    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_fwd       = r_fwd;
    assign o_fwd_data  = r_fwd_data;

endmodule

`default_nettype wire

// File: rtl/retry_backoff_drop_oldest_queue_top.sv
// ----------------------------------------------------------------------------
// retry_backoff_drop_oldest_queue_top
// Bounded drop-oldest send queue with linear retry backoff.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start high and busy low. Action
//   push appends i_payload, dropping the oldest entries when the queue is at
//   its limit; action outcome reports a send attempt on the head entry.
//   Every item gives one result on the o_ ports, marked by o_strobe for
//   exactly one cycle, in the cycle after the item is taken. The receiver cannot
//   hold results off, so none is ever delayed further.
//   Throughput is one item per cycle: busy stays low. The payload store is a
//   RAM with a registered read; the head word for the result is read in the
//   same cycle the item is taken, with a bypass when the new head is the
//   word being written by that push.
//   Configuration is a plain write port (enable, index, 16-bit data), used
//   only while no result is pending.
//   Reset (synchronous, active low) empties the queue, clears delay and
//   retry count, and loads the register defaults. The RAM needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module retry_backoff_drop_oldest_queue_top
    import rbq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_action,
    input  wire logic [DATA_WIDTH-1:0] i_payload,
    input  wire logic [1:0]            i_outcome,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_strobe,
    output logic                       o_head_valid,
    output logic [DATA_WIDTH-1:0]      o_head_payload,
    output logic [OCC_W-1:0]           o_occupancy,
    output logic [DELAY_W-1:0]         o_next_delay,
    output logic [RETRY_W-1:0]         o_retries_done,
    output logic                       o_overflow_drop,
    output logic                       o_retry_drop,
    output logic                       o_head_retired,
    output logic                       o_outcome_ignored
);

    localparam int PW = $clog2(DEPTH);

    logic                  accept;
    logic                  ram_we;
    logic [PW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [PW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    t_status               status;
    logic                  fwd;
    logic [DATA_WIDTH-1:0] fwd_data;

    // handshake
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // queue update logic
    rbq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_action    (i_action),
        .i_payload   (i_payload),
        .i_outcome   (i_outcome),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .o_strobe    (o_strobe),
        .o_status    (status),
        .o_fwd       (fwd),
        .o_fwd_data  (fwd_data)
    );

    // payload store
    rbq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // result fields, head word zero when empty
    assign o_head_valid      = status.head_valid;
    assign o_head_payload    = !status.head_valid ? '0 : (fwd ? fwd_data : ram_rdata);
    assign o_occupancy       = status.occupancy;
    assign o_next_delay      = status.next_delay;
    assign o_retries_done    = status.retries_done;
    assign o_overflow_drop   = status.overflow_drop;
    assign o_retry_drop      = status.retry_drop;
    assign o_head_retired    = status.head_retired;
    assign o_outcome_ignored = status.outcome_ignored;

    // every taken item yields a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_strobe)
        else $error("item taken without a result");

    // an ignored outcome leaves the queue empty
    a_ignored_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_outcome_ignored) |-> !o_head_valid)
        else $error("ignored outcome with a non-empty queue");

    // giving up a head restarts the retry count
    a_drop_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_retry_drop) |-> (o_retries_done == '0))
        else $error("retry drop left a retry count");

    // only an outcome item retires the head, and never together with a push drop
    a_retire_on_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_head_retired) |-> ($past(i_action) == ACT_OUTCOME && !o_overflow_drop))
        else $error("head retired by a push");

endmodule

`default_nettype wire

// File: tb/rbq_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rbq_result_checker
// Watches the item, configuration and result ports of the send queue, keeps
// its own copy of queue, backoff and retry state, and compares every result
// with the view predicted for the oldest accepted item.
// ----------------------------------------------------------------------------

module rbq_result_checker
    import rbq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int DW    = DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_busy,
    input  wire logic                  i_action,
    input  wire logic [DW-1:0]         i_payload,
    input  wire logic [1:0]            i_outcome,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_strobe,
    input  wire logic                  i_head_valid,
    input  wire logic [DW-1:0]         i_head_payload,
    input  wire logic [OCC_W-1:0]      i_occupancy,
    input  wire logic [DELAY_W-1:0]    i_next_delay,
    input  wire logic [RETRY_W-1:0]    i_retries_done,
    input  wire logic                  i_overflow_drop,
    input  wire logic                  i_retry_drop,
    input  wire logic                  i_head_retired,
    input  wire logic                  i_outcome_ignored,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int PTR_W     = $clog2(DEPTH);
    localparam int MAX_NOTES = 100;

    // one result as the block should present it
    typedef struct packed {
        logic               head_valid;
        logic [DW-1:0]      head_payload;
        logic [OCC_W-1:0]   occupancy;
        logic [DELAY_W-1:0] next_delay;
        logic [RETRY_W-1:0] retries_done;
        logic               overflow_drop;
        logic               retry_drop;
        logic               head_retired;
        logic               outcome_ignored;
    } t_queue_view;

    t_queue_view expected_views[$];
    t_queue_view oldest_view;
    t_queue_view new_view;

    // shadow queue state
    logic [DW-1:0]      word_store [DEPTH];
    logic [PTR_W-1:0]   rd_ptr;
    logic [PTR_W-1:0]   wr_ptr;
    logic [OCC_W-1:0]   held;
    logic [DELAY_W-1:0] delay_ms;
    logic [RETRY_W-1:0] retry_cnt;
    logic               evicted;

    // shadow registers
    logic [QLIM_W-1:0]        cfg_qlim;
    logic signed [RLIM_W-1:0] cfg_rlim;
    logic [DELAY_W-1:0]       cfg_base;
    logic [DELAY_W-1:0]       cfg_step;
    logic [DELAY_W-1:0]       cfg_max;

    // apply one item to the shadow state and return the resulting view
    function automatic t_queue_view predict_queue_view(input logic act,
                                                       input logic [DW-1:0] data,
                                                       input logic [1:0] code);
        t_queue_view        view;
        logic [OCC_W-1:0]   eff;
        logic [OCC_W-1:0]   drop;
        logic [DELAY_W-1:0] ceiling;
        logic [DELAY_W:0]   sum;
        logic               remove;
        view   = '0;
        remove = 1'b0;
        if (t_action'(act) == ACT_PUSH) begin
            // limit of zero acts as one, above the depth acts as the depth
            if (cfg_qlim == '0) begin
                eff = OCC_W'(1);
            end else if (cfg_qlim > DEPTH) begin
                eff = OCC_W'(DEPTH);
            end else begin
                eff = cfg_qlim;
            end
            // drop as many oldest entries as needed in one step
            if (held >= eff) begin
                drop   = held - eff + 1'b1;
                rd_ptr = rd_ptr + drop[PTR_W-1:0];
                held   = held - drop;
                view.overflow_drop = 1'b1;
                evicted = 1'b1;
            end
            word_store[wr_ptr] = data;
            wr_ptr = wr_ptr + 1'b1;
            held   = held + 1'b1;
        end else if (held == '0) begin
            view.outcome_ignored = 1'b1;
        end else begin
            if (t_outcome'(code) == OUT_RETRY) begin
                // linear backoff, ceiling never below base
                ceiling = (cfg_max < cfg_base) ? cfg_base : cfg_max;
                if (delay_ms == '0) begin
                    delay_ms = cfg_base;
                end else if (delay_ms < ceiling) begin
                    sum = {1'b0, delay_ms} + {1'b0, cfg_step};
                    delay_ms = (sum > {1'b0, ceiling}) ? ceiling : sum[DELAY_W-1:0];
                end
                if (cfg_rlim < 0) begin
                    if (retry_cnt != RETRY_SAT) retry_cnt = retry_cnt + 1'b1;
                end else if (int'(retry_cnt) < int'(cfg_rlim)) begin
                    retry_cnt = retry_cnt + 1'b1;
                end else begin
                    retry_cnt = '0;
                    view.retry_drop = 1'b1;
                    remove = 1'b1;
                end
            end else begin
                // success, fault and the spare code all retire the head
                delay_ms  = '0;
                retry_cnt = '0;
                remove    = 1'b1;
            end
            // a head already evicted by a push is not popped again
            if (remove && !evicted) begin
                rd_ptr = rd_ptr + 1'b1;
                held   = held - 1'b1;
                view.head_retired = 1'b1;
            end
            evicted = 1'b0;
        end
        view.head_valid   = (held != '0);
        view.head_payload = (held != '0) ? word_store[rd_ptr] : '0;
        view.occupancy    = held;
        view.next_delay   = delay_ms;
        view.retries_done = retry_cnt;
        return view;
    endfunction

    // compare one field and log the difference
    task automatic check_field(input string field, input logic [DW-1:0] want,
                               input logic [DW-1:0] got);
        if (want !== got) begin
            o_fail_count = o_fail_count + 1;
            if (o_fail_count <= MAX_NOTES) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, want, got);
            end
        end
    endtask

    // sample everything at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_views.delete();
            rd_ptr       = '0;
            wr_ptr       = '0;
            held         = '0;
            delay_ms     = '0;
            retry_cnt    = '0;
            evicted      = 1'b0;
            cfg_qlim     = QUEUE_LIMIT_RST;
            cfg_rlim     = RETRY_LIMIT_RST;
            cfg_base     = '0;
            cfg_step     = '0;
            cfg_max      = '0;
            o_fail_count = 0;
        end else begin
            // results first, so an item taken at this edge queues behind
            if (i_strobe) begin
                if (expected_views.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= MAX_NOTES) begin
                        $display("%0t: result with no item pending, expected none, actual %0h",
                                 $time, i_head_payload);
                    end
                end else begin
                    oldest_view = expected_views.pop_front();
                    check_field("head_valid", oldest_view.head_valid, i_head_valid);
                    check_field("head_payload", oldest_view.head_payload, i_head_payload);
                    check_field("occupancy", oldest_view.occupancy, i_occupancy);
                    check_field("next_delay", oldest_view.next_delay, i_next_delay);
                    check_field("retries_done", oldest_view.retries_done, i_retries_done);
                    check_field("overflow_drop", oldest_view.overflow_drop, i_overflow_drop);
                    check_field("retry_drop", oldest_view.retry_drop, i_retry_drop);
                    check_field("head_retired", oldest_view.head_retired, i_head_retired);
                    check_field("outcome_ignored", oldest_view.outcome_ignored,
                                i_outcome_ignored);
                end
            end
            // register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_QUEUE_LIMIT:  cfg_qlim = i_cfg_data[QLIM_W-1:0];
                    CFG_RETRY_LIMIT:  cfg_rlim = i_cfg_data[RLIM_W-1:0];
                    CFG_BACKOFF_BASE: cfg_base = i_cfg_data[DELAY_W-1:0];
                    CFG_BACKOFF_STEP: cfg_step = i_cfg_data[DELAY_W-1:0];
                    CFG_BACKOFF_MAX:  cfg_max  = i_cfg_data[DELAY_W-1:0];
                    default: ;
                endcase
            end
            // accepted item, appended at the tail
            if (i_start && !i_busy) begin
                new_view = predict_queue_view(i_action, i_payload, i_outcome);
                expected_views.insert(expected_views.size(), new_view);
            end
        end
        o_pending <= expected_views.size();
    end

endmodule

// File: tb/tb_retry_backoff_drop_oldest_queue_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_retry_backoff_drop_oldest_queue_top
// Drives pushes and send outcomes into the retry/backoff send queue: a
// directed pass over limits, evictions, give-ups and delay ceilings, retry
// streaks under unlimited and largest retry limits, a fill to full depth,
// then random phases under random register settings, some with random sender gaps.
// ----------------------------------------------------------------------------

module tb_retry_backoff_drop_oldest_queue_top;
    import rbq_pkg::*;

    localparam int DW          = DATA_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 118;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    logic                  busy;
    logic                  i_action   = 1'b0;
    logic [DW-1:0]         i_payload  = '0;
    logic [1:0]            i_outcome  = '0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_strobe;
    logic                  o_head_valid;
    logic [DW-1:0]         o_head_payload;
    logic [OCC_W-1:0]      o_occupancy;
    logic [DELAY_W-1:0]    o_next_delay;
    logic [RETRY_W-1:0]    o_retries_done;
    logic                  o_overflow_drop;
    logic                  o_retry_drop;
    logic                  o_head_retired;
    logic                  o_outcome_ignored;

    int          fail_count;
    int          pending_results;
    int unsigned cycle_count = 0;
    int          items_sent  = 0;
    bit          idle_on     = 1'b0;

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    retry_backoff_drop_oldest_queue_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_action          (i_action),
        .i_payload         (i_payload),
        .i_outcome         (i_outcome),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_strobe          (o_strobe),
        .o_head_valid      (o_head_valid),
        .o_head_payload    (o_head_payload),
        .o_occupancy       (o_occupancy),
        .o_next_delay      (o_next_delay),
        .o_retries_done    (o_retries_done),
        .o_overflow_drop   (o_overflow_drop),
        .o_retry_drop      (o_retry_drop),
        .o_head_retired    (o_head_retired),
        .o_outcome_ignored (o_outcome_ignored)
    );

    rbq_result_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_action          (i_action),
        .i_payload         (i_payload),
        .i_outcome         (i_outcome),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_strobe          (o_strobe),
        .i_head_valid      (o_head_valid),
        .i_head_payload    (o_head_payload),
        .i_occupancy       (o_occupancy),
        .i_next_delay      (o_next_delay),
        .i_retries_done    (o_retries_done),
        .i_overflow_drop   (o_overflow_drop),
        .i_retry_drop      (o_retry_drop),
        .i_head_retired    (o_head_retired),
        .i_outcome_ignored (o_outcome_ignored),
        .o_fail_count      (fail_count),
        .o_pending         (pending_results)
    );

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // present one item and hold it until taken, ends on a falling edge
    task automatic send_item(input t_action act, input logic [DW-1:0] data,
                             input t_outcome code);
        start     <= 1'b1;
        i_action  <= act;
        i_payload <= data;
        i_outcome <= code;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        items_sent = items_sent + 1;
    endtask

    task automatic push_word(input logic [DW-1:0] data);
        send_item(ACT_PUSH, data, t_outcome'($urandom_range(0, 3)));
    endtask

    task automatic report(input t_outcome code);
        send_item(ACT_OUTCOME, $urandom(), code);
    endtask

    // random sender gap
    task automatic pause_sender();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
    endtask

    // wait for the queue to drain its results, then load all registers
    task automatic set_config(input logic [CFG_DATA_W-1:0] qlim,
                              input logic [CFG_DATA_W-1:0] rlim,
                              input logic [CFG_DATA_W-1:0] base,
                              input logic [CFG_DATA_W-1:0] step,
                              input logic [CFG_DATA_W-1:0] ceil_ms);
        start <= 1'b0;
        do @(negedge i_clk); while (pending_results != 0);
        write_reg(CFG_QUEUE_LIMIT, qlim);
        write_reg(CFG_RETRY_LIMIT, rlim);
        write_reg(CFG_BACKOFF_BASE, base);
        write_reg(CFG_BACKOFF_STEP, step);
        write_reg(CFG_BACKOFF_MAX, ceil_ms);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [QLIM_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return QLIM_W'($urandom_range(1, 4));
            2:       return QLIM_W'($urandom_range(5, 20));
            3:       return QLIM_W'(DEPTH_DEF);
            4:       return QLIM_W'($urandom_range(DEPTH_DEF + 1, 255));
            default: return QLIM_W'($urandom_range(1, DEPTH_DEF));
        endcase
    endfunction

    function automatic logic [RLIM_W-1:0] pick_retry();
        case ($urandom_range(0, 5))
            0:       return '1;
            1:       return '0;
            2:       return RLIM_W'($urandom_range(1, 6));
            3:       return RLIM_W'(1023);
            4:       return RLIM_W'($urandom_range(1024, 2047));
            default: return RLIM_W'($urandom_range(1, 20));
        endcase
    endfunction

    function automatic logic [DELAY_W-1:0] pick_delay();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return DELAY_W'($urandom_range(1, 100));
            default: return DELAY_W'($urandom());
        endcase
    endfunction

    // random settings, with noise in the unused upper data bits
    task automatic random_config();
        logic [31:0] noise;
        noise = $urandom();
        set_config({noise[7:0], pick_limit()}, {noise[12:8], pick_retry()},
                   pick_delay(), pick_delay(), pick_delay());
    endtask

    task automatic random_outcome();
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k < 11) begin
            report(OUT_RETRY);
        end else if (k < 14) begin
            report(OUT_SUCCESS);
        end else if (k < 17) begin
            report(OUT_FAULT);
        end else begin
            report(OUT_SPARE);
        end
    endtask

    // one random step: push, single outcome, or a send attempt streak
    task automatic random_step(input int unsigned push_pct);
        int unsigned n;
        if ($urandom_range(0, 99) < push_pct) begin
            push_word($urandom());
            pause_sender();
        end else if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                report(OUT_RETRY);
                pause_sender();
            end
            random_outcome();
            pause_sender();
        end else begin
            random_outcome();
            pause_sender();
        end
    endtask

    initial begin
        int unsigned push_pct;
        int          target;

        // reset
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: small limits, eviction, give-up, all outcome codes
        set_config(16'd3, 16'd2, 16'd10, 16'd7, 16'd30);
        report(OUT_RETRY);
        push_word(32'h0000_0000);
        push_word(32'hFFFF_FFFF);
        push_word(32'hA5A5_A5A5);
        repeat (3) report(OUT_RETRY);
        push_word(32'h5A5A_5A5A);
        push_word(32'h1234_5678);
        report(OUT_RETRY);
        report(OUT_SUCCESS);
        report(OUT_FAULT);
        report(OUT_SPARE);
        report(OUT_SUCCESS);
        repeat (3) push_word($urandom());

        // limit lowered with entries held, ceiling below base, zero retries
        set_config(16'hFF01, 16'd0, 16'hFFFF, 16'hFFFF, 16'd100);
        push_word($urandom());
        report(OUT_RETRY);
        report(OUT_RETRY);

        // zero limit acts as one, delay step past the 16-bit range
        set_config(16'h0000, 16'hFFFF, 16'd60000, 16'd50000, 16'hFFFF);
        push_word($urandom());
        push_word($urandom());
        report(OUT_SUCCESS);
        report(OUT_RETRY);
        report(OUT_RETRY);

        // unlimited retries, delay above new ceiling
        set_config(16'd8, 16'h07FF, 16'd1, 16'd1, 16'd1024);
        repeat (3) push_word($urandom());
        repeat (30) report(OUT_RETRY);

        // largest retry limit: a long streak without give-up
        set_config(16'd8, 16'd1023, 16'd0, 16'd3, 16'd0);
        repeat (30) report(OUT_RETRY);
        report(OUT_FAULT);

        // fill to full depth with a limit above it
        set_config(16'd200, 16'd5, 16'd0, 16'd0, 16'd0);
        repeat (DEPTH_DEF + 6) push_word($urandom());

        // random phases, the last one without gaps
        for (int phase = 0; phase < PHASES; phase++) begin
            random_config();
            idle_on  = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
            push_pct = $urandom_range(25, 65);
            target   = items_sent + PHASE_ITEMS;
            while (items_sent < target) random_step(push_pct);
        end

        // drain and verdict
        start <= 1'b0;
        do @(negedge i_clk); while (pending_results != 0);
        repeat (4) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
